// File: design/swf_bit_record_parser_core_defines.svh
// Assertion macros shared by the checker of the bit record parser.
`ifndef SWF_BIT_RECORD_PARSER_CORE_DEFINES_SVH
`define SWF_BIT_RECORD_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SWF_BRP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SWF_BRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/swf_brp_pkg.sv
// Package of the bit record parser: field codes and controller/datapath interface types.
`default_nettype none
package swf_brp_pkg;

  localparam int WIDTH_FIELD_BITS = 5;
  localparam int VAL_W = 31;
  localparam int ID_W  = 4;

  localparam logic [ID_W-1:0] FID_XMIN    = 4'd0;
  localparam logic [ID_W-1:0] FID_YMAX    = 4'd3;
  localparam logic [ID_W-1:0] FID_SCALE_X = 4'd4;
  localparam logic [ID_W-1:0] FID_SCALE_Y = 4'd5;
  localparam logic [ID_W-1:0] FID_ROT_0   = 4'd6;
  localparam logic [ID_W-1:0] FID_ROT_1   = 4'd7;
  localparam logic [ID_W-1:0] FID_TRANS_X = 4'd8;
  localparam logic [ID_W-1:0] FID_TRANS_Y = 4'd9;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                        load;
    logic                        shift;
    logic                        consume;
    logic                        load_width;
    logic                        emit;
    logic                        zero;
    logic                        drop;
    logic [WIDTH_FIELD_BITS-1:0] need;
    logic [ID_W-1:0]             id;
    logic                        last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic                        avail;
    logic                        hit;
    logic                        cur_bit;
    logic [WIDTH_FIELD_BITS-1:0] width;
    logic                        out_free;
  } stat_t;

endpackage
`default_nettype wire

// File: design/swf_brp_ctrl.sv
// Controller of the bit record parser: record phase, field sequencing and handshake.
`default_nettype none
module swf_brp_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_kind,
  output logic                       in_tready,
  input  wire swf_brp_pkg::stat_t    stat,
  output swf_brp_pkg::cmd_t          cmd
);

  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_RWIDTH = 4'd1;
  localparam logic [3:0] PH_RFIELD = 4'd2;
  localparam logic [3:0] PH_SFLAG  = 4'd3;
  localparam logic [3:0] PH_SWIDTH = 4'd4;
  localparam logic [3:0] PH_SFIELD = 4'd5;
  localparam logic [3:0] PH_KFLAG  = 4'd6;
  localparam logic [3:0] PH_KWIDTH = 4'd7;
  localparam logic [3:0] PH_KFIELD = 4'd8;
  localparam logic [3:0] PH_TWIDTH = 4'd9;
  localparam logic [3:0] PH_TFIELD = 4'd10;

  logic [3:0]                          phase_r, phase_nxt;
  logic [swf_brp_pkg::ID_W-1:0]        nf_r, nf_nxt;
  logic                                is_field;
  logic                                is_flag;
  logic                                wzero;
  logic                                do_field;
  logic                                accept;

  assign is_field = (phase_r inside {PH_RFIELD, PH_SFIELD, PH_KFIELD, PH_TFIELD});
  assign is_flag  = (phase_r inside {PH_SFLAG, PH_KFLAG});
  assign wzero    = (stat.width == '0);
  assign in_tready = !stat.avail && !(is_field && wzero);
  assign accept   = in_tvalid && in_tready;

  always_comb begin
    cmd       = '0;
    phase_nxt = phase_r;
    nf_nxt    = nf_r;
    do_field  = 1'b0;
    if (is_flag) begin
      cmd.need = 5'd1;
    end else if (is_field) begin
      cmd.need = stat.width;
    end else begin
      cmd.need = 5'(swf_brp_pkg::WIDTH_FIELD_BITS);
    end

    if (accept) begin
      cmd.load = 1'b1;
      if (phase_r == PH_IDLE) begin
        phase_nxt = in_kind ? PH_SFLAG : PH_RWIDTH;
        nf_nxt    = swf_brp_pkg::FID_XMIN;
      end
    end else if (stat.out_free && is_field && wzero) begin
      // A zero width field takes no bits and is sent as zero right away.
      cmd.zero = 1'b1;
      do_field = 1'b1;
    end else if (stat.out_free && stat.avail) begin
      cmd.shift = 1'b1;
      if (stat.hit) begin
        cmd.consume = 1'b1;
        case (phase_r)
          PH_SFLAG: begin
            phase_nxt = stat.cur_bit ? PH_SWIDTH : PH_KFLAG;
          end
          PH_KFLAG: begin
            phase_nxt = stat.cur_bit ? PH_KWIDTH : PH_TWIDTH;
          end
          PH_RWIDTH: begin
            cmd.load_width = 1'b1;
            nf_nxt    = swf_brp_pkg::FID_XMIN;
            phase_nxt = PH_RFIELD;
          end
          PH_SWIDTH: begin
            cmd.load_width = 1'b1;
            nf_nxt    = swf_brp_pkg::FID_SCALE_X;
            phase_nxt = PH_SFIELD;
          end
          PH_KWIDTH: begin
            cmd.load_width = 1'b1;
            nf_nxt    = swf_brp_pkg::FID_ROT_0;
            phase_nxt = PH_KFIELD;
          end
          PH_TWIDTH: begin
            cmd.load_width = 1'b1;
            nf_nxt    = swf_brp_pkg::FID_TRANS_X;
            phase_nxt = PH_TFIELD;
          end
          PH_RFIELD, PH_SFIELD, PH_KFIELD, PH_TFIELD: begin
            do_field = 1'b1;
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end

    if (do_field) begin
      cmd.emit = 1'b1;
      case (phase_r)
        PH_RFIELD: begin
          cmd.id   = {2'b00, nf_r[1:0]};
          cmd.last = (nf_r[1:0] == swf_brp_pkg::FID_YMAX[1:0]);
          nf_nxt   = {2'b00, nf_r[1:0] + 2'd1};
          if (cmd.last) begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_SFIELD: begin
          cmd.id = nf_r;
          if (nf_r == swf_brp_pkg::FID_SCALE_Y) begin
            phase_nxt = PH_KFLAG;
          end else begin
            nf_nxt = swf_brp_pkg::FID_SCALE_Y;
          end
        end
        PH_KFIELD: begin
          cmd.id = nf_r;
          if (nf_r == swf_brp_pkg::FID_ROT_1) begin
            phase_nxt = PH_TWIDTH;
          end else begin
            nf_nxt = swf_brp_pkg::FID_ROT_1;
          end
        end
        default: begin
          if (nf_r == swf_brp_pkg::FID_TRANS_Y) begin
            cmd.id    = swf_brp_pkg::FID_TRANS_Y;
            cmd.last  = 1'b1;
            phase_nxt = PH_IDLE;
          end else begin
            cmd.id = swf_brp_pkg::FID_TRANS_X;
            nf_nxt = swf_brp_pkg::FID_TRANS_Y;
          end
        end
      endcase
      // The rest of the byte after a record's final field is padding.
      cmd.drop = cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      nf_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      nf_r    <= nf_nxt;
    end
  end

endmodule
`default_nettype wire

// File: design/swf_brp_dp.sv
// Datapath of the bit record parser: byte shifter, bit collector, width and output register.
`default_nettype none
module swf_brp_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic [7:0]                           in_byte,
  input  wire swf_brp_pkg::cmd_t                    cmd,
  output swf_brp_pkg::stat_t                        stat,
  input  wire logic                                 out_ready,
  output logic                                      out_valid,
  output logic [swf_brp_pkg::ID_W-1:0]              out_id,
  output logic [swf_brp_pkg::VAL_W-1:0]             out_value,
  output logic                                      out_last
);

  localparam int VW = swf_brp_pkg::VAL_W;
  localparam int WW = swf_brp_pkg::WIDTH_FIELD_BITS;

  logic [7:0]    byte_r, byte_nxt;
  logic [3:0]    left_r, left_nxt;
  logic [VW-1:0] acc_r, acc_nxt, acc_sh;
  logic [WW-1:0] cnt_r, cnt_nxt, cnt_sh;
  logic [WW-1:0] width_r, width_nxt;
  logic          ov_r, ov_nxt;
  logic [swf_brp_pkg::ID_W-1:0] oid_r, oid_nxt;
  logic [VW-1:0] oval_r, oval_nxt;
  logic          olast_r, olast_nxt;
  logic [VW-1:0] ext_mask;
  logic [VW-1:0] sext;

  assign acc_sh   = {acc_r[VW-2:0], byte_r[7]};
  assign cnt_sh   = cnt_r + 5'd1;
  assign ext_mask = {VW{1'b1}} << cmd.need;
  // need is at least one whenever a collected value is sign-extended.
  assign sext     = acc_sh[cmd.need - 5'd1] ? (acc_sh | ext_mask) : acc_sh;

  assign stat.avail    = (left_r != 4'd0);
  assign stat.hit      = (cnt_sh == cmd.need);
  assign stat.cur_bit  = byte_r[7];
  assign stat.width    = width_r;
  assign stat.out_free = !ov_r || out_ready;

  always_comb begin
    byte_nxt  = byte_r;
    left_nxt  = left_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    width_nxt = width_r;
    ov_nxt    = ov_r && !out_ready;
    oid_nxt   = oid_r;
    oval_nxt  = oval_r;
    olast_nxt = olast_r;
    if (cmd.load) begin
      byte_nxt = in_byte;
      left_nxt = 4'd8;
    end
    if (cmd.shift) begin
      byte_nxt = {byte_r[6:0], 1'b0};
      left_nxt = left_r - 4'd1;
      acc_nxt  = cmd.consume ? '0 : acc_sh;
      cnt_nxt  = cmd.consume ? '0 : cnt_sh;
    end
    if (cmd.load_width) begin
      width_nxt = acc_sh[WW-1:0];
    end
    if (cmd.emit) begin
      ov_nxt    = 1'b1;
      oid_nxt   = cmd.id;
      oval_nxt  = cmd.zero ? '0 : sext;
      olast_nxt = cmd.last;
    end
    if (cmd.drop) begin
      left_nxt = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= '0;
      acc_r   <= '0;
      cnt_r   <= '0;
      width_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      left_r  <= left_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      width_r <= width_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r  <= byte_nxt;
    oid_r   <= oid_nxt;
    oval_r  <= oval_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid = ov_r;
  assign out_id    = oid_r;
  assign out_value = oval_r;
  assign out_last  = olast_r;

endmodule
`default_nettype wire

// File: design/swf_bit_record_parser_core.sv
// Top level of the bit-packed RECT / MATRIX record parser.
//
//   Channel  Direction  Contents
//   in_      slave      tdata = raw record byte, tuser = record kind (0 RECT, 1 MATRIX)
//   out_     master     tdata = field id and sign-extended value, tlast = final field
//
// Each input beat is first loaded and then shifted bit by bit through the single-bit
// shifter in the datapath; every field of zero width adds a step of its own.
// A record's final field ends the beat early because the padding behind it is dropped.
// Reset is synchronous and active low; it returns the parser to the start of a record.
// The parser only shifts bits while the output register is empty or being read, so a
// stalled result holds every bit step; a used-up byte can still be replaced meanwhile.
`default_nettype none
module swf_bit_record_parser_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tuser,   // [0] kind, sampled on a record's first beat
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [3:0] field_id, [34:4] field_value, [39:35] zero
  output logic             out_tlast   // final field of the record
);

  swf_brp_pkg::cmd_t  cmd;
  swf_brp_pkg::stat_t stat;

  logic [swf_brp_pkg::ID_W-1:0]  out_id;
  logic [swf_brp_pkg::VAL_W-1:0] out_value;

  // The controller tracks where in the record the parser stands and which field
  // comes next; the datapath holds the bits and forms the values.
  swf_brp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_kind   (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  swf_brp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_byte   (in_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_id    (out_id),
    .out_value (out_value),
    .out_last  (out_tlast)
  );

  // The output beat packs the field id low, the value above it, and zero padding.
  assign out_tdata = {5'd0, out_value, out_id};

endmodule
`default_nettype wire

// File: design/swf_brp_checker.sv
// Port checker of the bit record parser and its bind to the top level.
`default_nettype none
`include "swf_bit_record_parser_core_defines.svh"
module swf_brp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic        out_tlast
);

  logic in_beat;
  logic [3:0] fid;

  assign in_beat = in_tvalid && in_tready;
  assign fid     = out_tdata[3:0];

  `SWF_BRP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled output beat changed")
  `SWF_BRP_ASSERT_NEXT(a_busy_after_beat, in_beat, !in_tready, "input taken again right after a beat")
  `SWF_BRP_ASSERT_NOW(a_id_range, out_tvalid, fid <= swf_brp_pkg::FID_TRANS_Y, "field id out of range")
  `SWF_BRP_ASSERT_NOW(a_pad_zero, out_tvalid, out_tdata[39:35] == 5'd0, "output padding not zero")
  `SWF_BRP_ASSERT_NOW(a_last_id, out_tvalid && out_tlast, fid == swf_brp_pkg::FID_YMAX || fid == swf_brp_pkg::FID_TRANS_Y, "last on a field that cannot end a record")

endmodule

bind swf_bit_record_parser_core swf_brp_checker u_swf_brp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire
